// ===== rtl/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, defaults and codes for the swap slot bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  localparam int ENTRY_W  = 23;
  localparam int SLOT_W   = 15;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 15;

  localparam int SLOT_SHIFT = 8;
  localparam int SLOT_LIMIT = 32768;

  localparam int DEF_BITMAP_WORDS = 1024;
  localparam int DEF_WORD_BITS    = 32;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 16'd32768;

endpackage

`default_nettype wire

// ===== rtl/bitmap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// First-fit allocator over a bitmap of swap slots held in one memory, with a
// word-at-a-time scan for allocation and a reciprocal multiply for frees.
// ----------------------------------------------------------------------------
//
//   port group        direction  meaning
//   start/busy        in/out     request beat: kind, entry
//   done              out        result beat: alloc_entry, status, free_slots
//   cfg_we/cfg_data   in         slot_count register write
//
// An allocate reads and then checks one bitmap word at a time, set by the
// single memory read port and the shared word check. A free goes through the
// reciprocal multiply for the word index, the bit offset and the memory read;
// a free of slot 0 or out of range goes straight to the result beat.
// After reset a clearing pass over all BITMAP_WORDS words zeroes the bitmap
// while busy is high. The result beat lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator #(
  parameter int BITMAP_WORDS = bsa_pkg::DEF_BITMAP_WORDS,
  parameter int WORD_BITS    = bsa_pkg::DEF_WORD_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          kind,
  input  wire logic [bsa_pkg::ENTRY_W-1:0]   entry,
  output logic                               done,
  output logic [bsa_pkg::ENTRY_W-1:0]        alloc_entry,
  output logic [bsa_pkg::STATUS_W-1:0]       status,
  output logic [bsa_pkg::FREE_W-1:0]         free_slots,
  input  wire logic                          cfg_we,
  input  wire logic [bsa_pkg::COUNT_W-1:0]   cfg_data
);

  import bsa_pkg::*;

  localparam int ADDR_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int TOTAL_BITS = BITMAP_WORDS * WORD_BITS;
  localparam int CAP_LIM = (TOTAL_BITS < SLOT_LIMIT) ? TOTAL_BITS : SLOT_LIMIT;
  localparam logic [COUNT_W-1:0] CAP_LIM_V = COUNT_W'(CAP_LIM);
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(BITMAP_WORDS - 1);
  localparam int RECIP_K = SLOT_W + BIT_W;
  localparam int RECIP_W = SLOT_W + 2;
  localparam int PROD_W  = SLOT_W + RECIP_W;
  localparam int QUOT_W  = PROD_W - RECIP_K;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_K) + WORD_BITS - 1) / WORD_BITS);
  localparam logic [SLOT_W-1:0] WORD_BITS_V = SLOT_W'(WORD_BITS);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_A_READ  = 3'd2;
  localparam logic [2:0] S_A_CHECK = 3'd3;
  localparam logic [2:0] S_F_DIV   = 3'd4;
  localparam logic [2:0] S_F_READ  = 3'd5;
  localparam logic [2:0] S_F_CHECK = 3'd6;
  localparam logic [2:0] S_FINISH  = 3'd7;

  logic [2:0]           state;
  logic [COUNT_W-1:0]   slot_count;
  logic [COUNT_W-1:0]   used_slots;
  logic [ADDR_W-1:0]    ptr;
  logic [COUNT_W-1:0]   base;
  logic [SLOT_W-1:0]    slot_q;
  logic [QUOT_W-1:0]    word_q;
  logic [BIT_W-1:0]     bit_q;
  logic [ENTRY_W-1:0]   res_entry;
  logic [STATUS_W-1:0]  res_status;

  logic [WORD_BITS-1:0] mem [BITMAP_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wd;

  logic [COUNT_W-1:0]   cap;
  logic [COUNT_W-1:0]   avail;
  logic [COUNT_W-1:0]   free_cnt;
  logic [SLOT_W-1:0]    req_slot;
  logic [COUNT_W:0]     span;
  logic [COUNT_W:0]     base_step;
  logic [WORD_BITS-1:0] open_bits;
  logic                 hit;
  logic [BIT_W-1:0]     hit_idx;
  logic [COUNT_W-1:0]   hit_slot;
  logic [PROD_W-1:0]    quot_prod;
  logic [QUOT_W-1:0]    quot;
  logic [SLOT_W-1:0]    word_base;
  logic [SLOT_W-1:0]    bit_off;

  assign busy = (state != S_IDLE);

  always_comb begin
    cap = (slot_count > CAP_LIM_V) ? CAP_LIM_V : slot_count;
    avail = (cap > COUNT_W'(1)) ? cap - COUNT_W'(1) : '0;
    free_cnt = (avail > used_slots) ? avail - used_slots : '0;
    req_slot = entry[SLOT_SHIFT +: SLOT_W];
    span = {1'b0, cap} - {1'b0, base};
    base_step = {1'b0, base} + (COUNT_W + 1)'(WORD_BITS);
    for (int b = 0; b < WORD_BITS; b++) begin
      open_bits[b] = !rd_data[b] && (span > (COUNT_W + 1)'(b)) &&
                     !((base == '0) && (b == 0));
    end
    hit = 1'b0;
    hit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (open_bits[b]) begin
        hit = 1'b1;
        hit_idx = BIT_W'(b);
      end
    end
    hit_slot = base + COUNT_W'(hit_idx);
    quot_prod = PROD_W'(slot_q) * PROD_W'(RECIP);
    quot = quot_prod[PROD_W-1:RECIP_K];
    word_base = SLOT_W'(word_q) * WORD_BITS_V;
    bit_off = slot_q - word_base;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wd = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_A_CHECK: begin
        mem_we = hit;
        mem_wd = rd_data | (WORD_BITS'(1) << hit_idx);
      end
      S_F_CHECK: begin
        mem_we = rd_data[bit_q];
        mem_wd = rd_data & ~(WORD_BITS'(1) << bit_q);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr] <= mem_wd;
    end
    rd_data <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      slot_q <= req_slot;
    end
    if (state == S_F_DIV) begin
      word_q <= quot;
    end
    if (state == S_F_READ) begin
      bit_q <= bit_off[BIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      slot_count <= SLOT_COUNT_RESET;
      used_slots <= '0;
      ptr <= '0;
      base <= '0;
      res_entry <= '0;
      res_status <= ST_OK;
      done <= 1'b0;
      alloc_entry <= '0;
      status <= ST_OK;
      free_slots <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        slot_count <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          if (ptr == LAST_WORD) begin
            ptr <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            res_entry <= '0;
            res_status <= ST_OK;
            ptr <= '0;
            base <= '0;
            if (kind == KIND_ALLOC) begin
              state <= S_A_READ;
            end else if ((req_slot == '0) || ({1'b0, req_slot} >= cap)) begin
              res_status <= ST_BAD;
              state <= S_FINISH;
            end else begin
              state <= S_F_DIV;
            end
          end
        end
        S_A_READ: begin
          state <= S_A_CHECK;
        end
        S_A_CHECK: begin
          if (hit) begin
            used_slots <= used_slots + COUNT_W'(1);
            res_entry <= {hit_slot[SLOT_W-1:0], SLOT_SHIFT'(0)};
            state <= S_FINISH;
          end else if (base_step >= {1'b0, cap}) begin
            res_status <= ST_FULL;
            state <= S_FINISH;
          end else begin
            base <= base_step[COUNT_W-1:0];
            ptr <= ptr + ADDR_W'(1);
            state <= S_A_READ;
          end
        end
        S_F_DIV: begin
          ptr <= ADDR_W'(quot);
          state <= S_F_READ;
        end
        S_F_READ: begin
          state <= S_F_CHECK;
        end
        S_F_CHECK: begin
          if (rd_data[bit_q]) begin
            if (used_slots != '0) begin
              used_slots <= used_slots - COUNT_W'(1);
            end
          end else begin
            res_status <= ST_BAD;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          done <= 1'b1;
          alloc_entry <= res_entry;
          status <= res_status;
          free_slots <= free_cnt[FREE_W-1:0];
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swap slot allocator testbench
// Drives allocate and free requests into the bitmap slot allocator through its
// start/busy handshake and checks each result beat against its table answer
// or a bit-true model of the slot bitmap and used-slot counter. A short table
// covers the extremes of the slot count, full devices and bad or duplicate
// frees. Random phases follow, each under its own slot count, mixing frees of
// held slots with allocations and malformed frees.
// ----------------------------------------------------------------------------
module tb;
  import bsa_pkg::*;

  localparam int SLOT_SPAN    = DEF_BITMAP_WORDS * DEF_WORD_BITS;
  localparam int RANDOM_ITEMS = 1750;
  localparam int QUIET_ITEMS  = 200;
  localparam int FREE_MAX     = (1 << FREE_W) - 1;

  typedef struct packed {
    logic [ENTRY_W-1:0]  alloc_entry;
    logic [STATUS_W-1:0] status;
    logic [FREE_W-1:0]   free_slots;
  } answer_t;

  typedef struct packed {
    logic               set_count;
    logic [COUNT_W-1:0] count;
    logic               kind;
    logic [ENTRY_W-1:0] entry;
    logic               typed;
    answer_t            answer;
  } row_t;

  logic                clk;
  logic                rst      = 1'b1;
  logic                start    = 1'b0;
  logic                kind     = KIND_ALLOC;
  logic [ENTRY_W-1:0]  entry    = '0;
  logic                cfg_we   = 1'b0;
  logic [COUNT_W-1:0]  cfg_data = '0;
  logic                busy;
  logic                done;
  logic [ENTRY_W-1:0]  alloc_entry;
  logic [STATUS_W-1:0] status;
  logic [FREE_W-1:0]   free_slots;

  bit                  slot_map [SLOT_SPAN];
  logic [COUNT_W-1:0]  used_count   = '0;
  logic [COUNT_W-1:0]  slot_count_q = SLOT_COUNT_RESET;
  int unsigned         held_slots [$];
  answer_t             expected_answers [$];
  int unsigned         mismatches   = 0;

  row_t plan [19] = '{
    '{1'b0, 16'd0,     KIND_ALLOC, 23'h000000, 1'b1, '{23'h000100, ST_OK,   15'd32766}},
    '{1'b0, 16'd0,     KIND_ALLOC, 23'h000000, 1'b1, '{23'h000200, ST_OK,   15'd32765}},
    '{1'b0, 16'd0,     KIND_FREE,  23'h0001FF, 1'b1, '{23'h000000, ST_OK,   15'd32766}},
    '{1'b0, 16'd0,     KIND_FREE,  23'h0001FF, 1'b1, '{23'h000000, ST_BAD,  15'd32766}},
    '{1'b0, 16'd0,     KIND_FREE,  23'h0000FF, 1'b1, '{23'h000000, ST_BAD,  15'd32766}},
    '{1'b0, 16'd0,     KIND_ALLOC, 23'h000000, 1'b1, '{23'h000100, ST_OK,   15'd32765}},
    '{1'b0, 16'd0,     KIND_FREE,  23'h7FFFFF, 1'b1, '{23'h000000, ST_BAD,  15'd32765}},
    '{1'b1, 16'd3,     KIND_ALLOC, 23'h000000, 1'b1, '{23'h000000, ST_FULL, 15'd0}},
    '{1'b0, 16'd0,     KIND_FREE,  23'h000300, 1'b1, '{23'h000000, ST_BAD,  15'd0}},
    '{1'b1, 16'd0,     KIND_ALLOC, 23'h000000, 1'b1, '{23'h000000, ST_FULL, 15'd0}},
    '{1'b1, 16'd1,     KIND_ALLOC, 23'h000000, 1'b1, '{23'h000000, ST_FULL, 15'd0}},
    '{1'b1, 16'd2,     KIND_FREE,  23'h000100, 1'b1, '{23'h000000, ST_OK,   15'd0}},
    '{1'b0, 16'd0,     KIND_ALLOC, 23'h000000, 1'b1, '{23'h000100, ST_OK,   15'd0}},
    '{1'b0, 16'd0,     KIND_FREE,  23'h0002AA, 1'b1, '{23'h000000, ST_BAD,  15'd0}},
    '{1'b1, 16'd65535, KIND_FREE,  23'h000255, 1'b1, '{23'h000000, ST_OK,   15'd32766}},
    '{1'b0, 16'd0,     KIND_ALLOC, 23'h7FFFFF, 1'b1, '{23'h000200, ST_OK,   15'd32765}},
    '{1'b1, 16'd32768, KIND_ALLOC, 23'h000000, 1'b0, '0},
    '{1'b0, 16'd0,     KIND_FREE,  23'h7FFF00, 1'b0, '0},
    '{1'b1, 16'd40000, KIND_ALLOC, 23'h2A5A5A, 1'b0, '0}
  };

  bitmap_slot_allocator uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .entry       (entry),
    .done        (done),
    .alloc_entry (alloc_entry),
    .status      (status),
    .free_slots  (free_slots),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int unsigned usable_cap();
    int unsigned cap;
    cap = 32'(slot_count_q);
    if (cap > SLOT_SPAN) cap = SLOT_SPAN;
    if (cap > SLOT_LIMIT) cap = SLOT_LIMIT;
    return cap;
  endfunction

  function automatic logic [FREE_W-1:0] slots_left();
    int unsigned cap;
    int unsigned avail;
    int unsigned left;
    cap = usable_cap();
    avail = (cap > 1) ? cap - 1 : 0;
    left = (avail > 32'(used_count)) ? avail - 32'(used_count) : 0;
    if (left > FREE_MAX) left = FREE_MAX;
    return left[FREE_W-1:0];
  endfunction

  function automatic answer_t apply_request(logic k, logic [ENTRY_W-1:0] e);
    answer_t     a;
    int unsigned cap;
    int unsigned s;
    a = '0;
    cap = usable_cap();
    if (k == KIND_ALLOC) begin
      a.status = ST_FULL;
      for (s = 1; s < cap; s++) begin
        if (!slot_map[s]) begin
          slot_map[s] = 1'b1;
          used_count = used_count + 1'b1;
          a.alloc_entry = {s[SLOT_W-1:0], {SLOT_SHIFT{1'b0}}};
          a.status = ST_OK;
          held_slots.push_back(s);
          break;
        end
      end
    end else begin
      s = 32'(e[ENTRY_W-1:SLOT_SHIFT]);
      if (s == 0 || s >= cap || !slot_map[s]) begin
        a.status = ST_BAD;
      end else begin
        slot_map[s] = 1'b0;
        if (used_count > 0) used_count = used_count - 1'b1;
        foreach (held_slots[i]) begin
          if (held_slots[i] == s) begin
            held_slots.delete(i);
            break;
          end
        end
      end
    end
    a.free_slots = slots_left();
    return a;
  endfunction

  task automatic issue_request(logic k, logic [ENTRY_W-1:0] e, logic typed, answer_t want);
    answer_t predicted;
    start <= 1'b1;
    kind  <= k;
    entry <= e;
    do @(posedge clk); while (busy);
    predicted = apply_request(k, e);
    expected_answers.push_back(typed ? want : predicted);
  endtask

  task automatic rest_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (expected_answers.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slot_count(logic [COUNT_W-1:0] value);
    wait_quiet();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_count_q = value;
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: entry %h status %0d free %0d",
                   alloc_entry, status, free_slots);
      end else begin
        want = expected_answers.pop_front();
        if (alloc_entry !== want.alloc_entry || status !== want.status ||
            free_slots !== want.free_slots) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected entry %h status %0d free %0d,",
                      " got entry %h status %0d free %0d"},
                     want.alloc_entry, want.status, want.free_slots,
                     alloc_entry, status, free_slots);
        end
      end
    end
  end

  initial begin
    int unsigned  issued;
    int unsigned  phase_len;
    int unsigned  phase_done;
    int unsigned  alloc_bias;
    int unsigned  roll;
    int unsigned  cap;
    int unsigned  pick;
    int unsigned  s;
    logic [31:0]  noise;
    logic         k;
    logic [ENTRY_W-1:0] e;
    logic [COUNT_W-1:0] count;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].set_count) write_slot_count(plan[i].count);
      issue_request(plan[i].kind, plan[i].entry, plan[i].typed, plan[i].answer);
      if ($urandom_range(0, 3) == 0) rest_cycles($urandom_range(1, 3));
    end

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0:       count = 16'd0;
        1:       count = 16'd1;
        2:       count = 16'd2;
        3:       count = 16'd65535;
        4:       count = 16'($urandom_range(500, 65535));
        5, 6:    count = 16'($urandom_range(65, 600));
        default: count = 16'($urandom_range(2, 64));
      endcase
      write_slot_count(count);
      phase_len  = $urandom_range(20, 90);
      alloc_bias = $urandom_range(25, 85);
      phase_done = 0;
      while (phase_done < phase_len && issued < RANDOM_ITEMS) begin
        if (issued < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(0, 3) == 0)
          rest_cycles($urandom_range(1, 3));
        cap   = usable_cap();
        roll  = $urandom_range(0, 99);
        noise = $urandom;
        k     = KIND_FREE;
        e     = noise[ENTRY_W-1:0];
        if (roll < alloc_bias) begin
          k = KIND_ALLOC;
        end else if (roll < 92 && held_slots.size() != 0) begin
          pick = $urandom_range(0, held_slots.size() - 1);
          for (int t = 0; t < 8 && held_slots[pick] >= cap; t++)
            pick = $urandom_range(0, held_slots.size() - 1);
          s = held_slots[pick];
          e = {s[SLOT_W-1:0], noise[SLOT_SHIFT-1:0]};
        end else begin
          case ($urandom_range(0, 3))
            0: s = 32'(noise[ENTRY_W-1:SLOT_SHIFT]);
            1: s = 0;
            2: s = (cap <= FREE_MAX) ? $urandom_range(cap, FREE_MAX) : 0;
            default: s = (cap > 1) ? $urandom_range(1, cap - 1) : 0;
          endcase
          e = {s[SLOT_W-1:0], noise[SLOT_SHIFT-1:0]};
        end
        issue_request(k, e, 1'b0, '0);
        issued++;
        phase_done++;
      end
    end

    start <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
